// ----- hdl/pidset_pkg.sv -----
// Shared constants and controller/datapath interface types for the packet id set.
`timescale 1ns / 1ps

package pidset_pkg;

    // Table size and derived widths
    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LIM_W   = (CNT_W > 5) ? CNT_W : 5;
    localparam int ID_W    = 16;
    localparam int ACT_W   = 2;
    localparam int CFG_W   = 5;
    localparam int ENTRY_W = 5;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the accepted item, restart the scan
        logic rd;       // read the slot at the scan index, advance the index
        logic commit;   // apply the action and load the result register
    } pidset_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;  // scan index is at the last slot
        logic out_hold;   // result register is full and stalled
    } pidset_sts_t;

endpackage

// ----- hdl/pidset_ctrl.sv -----
// Sequencer for the packet id set: accept, scan all slots, drain, commit.
`timescale 1ns / 1ps

module pidset_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  pidset_pkg::pidset_sts_t  sts,
    output pidset_pkg::pidset_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Take a new item only while idle
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!sts.out_hold)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/pidset_dp.sv -----
// Datapath for the packet id set: slot memory, valid bits, scan compare, result register.
`timescale 1ns / 1ps

module pidset_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pidset_pkg::pidset_cmd_t              cmd,
    output pidset_pkg::pidset_sts_t              sts,
    input  logic [pidset_pkg::ACT_W-1:0]         action,
    input  logic [pidset_pkg::ID_W-1:0]          pkt_id,
    input  logic                                 cfg_wr_en,
    input  logic [pidset_pkg::CFG_W-1:0]         cfg_wr_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 ok,
    output logic [pidset_pkg::ENTRY_W-1:0]       entry_count
);

    localparam int DEPTH = pidset_pkg::DEPTH;
    localparam int IDX_W = pidset_pkg::IDX_W;
    localparam int CNT_W = pidset_pkg::CNT_W;
    localparam int LIM_W = pidset_pkg::LIM_W;

    // Slot memory and valid bits
    logic [pidset_pkg::ID_W-1:0]   id_mem [DEPTH];
    logic [DEPTH-1:0]              valid_reg;
    logic [DEPTH-1:0]              valid_next;

    // Item being worked on
    logic [pidset_pkg::ACT_W-1:0]  act_reg;
    logic [pidset_pkg::ID_W-1:0]   id_reg;

    // Scan state
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              cmp_idx_reg;
    logic                          cmp_vld_reg;
    logic [pidset_pkg::ID_W-1:0]   rd_data_reg;
    logic                          found_reg;
    logic [IDX_W-1:0]              found_idx_reg;
    logic                          free_reg;
    logic [IDX_W-1:0]              free_idx_reg;

    // Set state and configuration
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [pidset_pkg::CFG_W-1:0]  cap_reg;

    // Result register
    logic                          out_valid_reg;
    logic                          ok_reg;
    logic [pidset_pkg::ENTRY_W-1:0] entry_count_reg;

    logic                          hit;
    logic                          free_hit;
    logic [LIM_W-1:0]              cap_ext;
    logic [LIM_W-1:0]              limit;
    logic                          room;
    logic                          add_ok;
    logic                          ok_next;

    // Compare the slot read in the previous cycle
    assign hit      = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_data_reg == id_reg);
    assign free_hit = cmp_vld_reg && !valid_reg[cmp_idx_reg];

    // Effective limit: zero or above depth means the full table
    assign cap_ext = LIM_W'(cap_reg);
    assign limit   = ((cap_ext == '0) || (cap_ext > LIM_W'(DEPTH))) ? LIM_W'(DEPTH) : cap_ext;
    assign room    = (LIM_W'(count_reg) < limit);
    assign add_ok  = !found_reg && room && free_reg;

    assign sts.scan_last = (idx_reg == IDX_W'(DEPTH - 1));
    assign sts.out_hold  = out_valid_reg && out_stall;

    // Apply the action
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        ok_next    = 1'b0;
        unique case (act_reg)
            pidset_pkg::ACT_QUERY:
            begin
                ok_next = found_reg;
            end
            pidset_pkg::ACT_ADD:
            begin
                ok_next = add_ok;
                if (add_ok)
                begin
                    valid_next[free_idx_reg] = 1'b1;
                    count_next               = count_reg + CNT_W'(1);
                end
            end
            pidset_pkg::ACT_REMOVE:
            begin
                ok_next = found_reg;
                if (found_reg)
                begin
                    valid_next[found_idx_reg] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            pidset_pkg::ACT_CLEAR:
            begin
                ok_next    = 1'b1;
                valid_next = '0;
                count_next = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Slot memory: write on a successful add, registered read during the scan
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (act_reg == pidset_pkg::ACT_ADD) && add_ok)
        begin
            id_mem[free_idx_reg] <= id_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= id_mem[idx_reg];
        end
    end

    // Payload registers of the item and the scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            id_reg  <= pkt_id;
        end
        if (cmd.rd)
        begin
            cmp_idx_reg <= idx_reg;
        end
        if (hit && !found_reg)
        begin
            found_idx_reg <= cmp_idx_reg;
        end
        if (free_hit && !free_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.commit)
        begin
            ok_reg          <= ok_next;
            entry_count_reg <= pidset_pkg::ENTRY_W'(count_next);
        end
    end

    // Control state: scan index, match flags, set contents, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            cap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.rd;
            if (cmd.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.rd)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
                if (free_hit)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign entry_count = entry_count_reg;

endmodule

// ----- hdl/packet_id_tracking_set_core.sv -----
// Sequence: the accepted item is loaded, the scan reads one slot per cycle, then a drain state and
// a commit state that loads the result register; commit waits while that register is stalled.
// A new item is accepted while the previous result still waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the set and sets the capacity limit (cap_reg) to 0.
// No clearing pass: slot valid bits are cleared at once by reset.
`timescale 1ns / 1ps

module packet_id_tracking_set_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pidset_pkg::ACT_W-1:0]         action,
    input  logic [pidset_pkg::ID_W-1:0]          pkt_id,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 ok,
    output logic [pidset_pkg::ENTRY_W-1:0]       entry_count,
    input  logic                                 cfg_wr_en,
    input  logic [pidset_pkg::CFG_W-1:0]         cfg_wr_data
);

    pidset_pkg::pidset_cmd_t cmd;
    pidset_pkg::pidset_sts_t sts;

    // Sequencer
    pidset_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Slot storage, compare and result
    pidset_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .action      (action),
        .pkt_id      (pkt_id),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .entry_count (entry_count)
    );

    // Block is busy in the cycle after an item is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // A new result appears only at the end of an item's work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in work");

    // Load, scan and commit commands never overlap
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.rd, cmd.commit}))
        else $error("overlapping controller commands");

endmodule
